### src/neighbour_edge_weights_assert.svh
// Assertion macros shared by the neighbour edge weight RTL.
// Each macro expects signals named clk and rst in the using scope.
`ifndef NEIGHBOUR_EDGE_WEIGHTS_ASSERT_SVH
`define NEIGHBOUR_EDGE_WEIGHTS_ASSERT_SVH

`ifndef ASSERT_OFF
`define NLW_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");
`define NLW_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: implication");
`define NLW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");
`else
`define NLW_ASSERT_NEVER(lbl, expr)
`define NLW_ASSERT_IMPLY(lbl, pre, post)
`define NLW_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### src/nlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlw_pkg
// Shared types, register codes and the exponent step table of the
// neighbour edge weight block.
// ----------------------------------------------------------------------------
package nlw_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_BETA_SCALE  = 2'd1;
  localparam logic [1:0] REG_GAMMA_SCALE = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WEIGHT_W   = 22;
  localparam int unsigned EXP_STEPS  = 20;

  // 1/sqrt2 in Q0.16
  localparam logic [15:0] INV_SQRT2 = 16'd46341;

  // neighbour order inside an item
  localparam logic [1:0] NB_LEFT    = 2'd0;
  localparam logic [1:0] NB_UPLEFT  = 2'd1;
  localparam logic [1:0] NB_UP      = 2'd2;
  localparam logic [1:0] NB_UPRIGHT = 2'd3;

  // one classified pixel with its neighbour colors
  typedef struct packed {
    logic [23:0] pix;
    logic [23:0] left;
    logic [23:0] upleft;
    logic [23:0] up;
    logic [23:0] upright;
    logic [3:0]  ok;  // bit per neighbour, set when it lies inside the image
  } item_t;

  // round(65536 * exp(-2^k)) for k = 3 down to -16
  function automatic logic [15:0] exp_step(input logic [4:0] i);
    logic [15:0] t;
    t = 16'd0;
    unique case (i)
      5'd0:    t = 16'd22;
      5'd1:    t = 16'd1200;
      5'd2:    t = 16'd8869;
      5'd3:    t = 16'd24109;
      5'd4:    t = 16'd39750;
      5'd5:    t = 16'd51039;
      5'd6:    t = 16'd57835;
      5'd7:    t = 16'd61565;
      5'd8:    t = 16'd63520;
      5'd9:    t = 16'd64520;
      5'd10:   t = 16'd65026;
      5'd11:   t = 16'd65280;
      5'd12:   t = 16'd65408;
      5'd13:   t = 16'd65472;
      5'd14:   t = 16'd65504;
      5'd15:   t = 16'd65520;
      5'd16:   t = 16'd65528;
      5'd17:   t = 16'd65532;
      5'd18:   t = 16'd65534;
      5'd19:   t = 16'd65535;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

### src/nlw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/nlw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlw_queue
// Two-entry request queue between the pixel front end and the weight engine.
// ----------------------------------------------------------------------------
`include "neighbour_edge_weights_assert.svh"

module nlw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nlw_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output nlw_pkg::item_t pop_data,
  output logic           empty
);

  nlw_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  // store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `NLW_ASSERT_NEVER(a_no_overflow, push && full)
  `NLW_ASSERT_NEVER(a_no_underflow, pop && empty)
  `NLW_ASSERT_NEVER(a_count_range, count == 2'd3)

endmodule

### src/nlw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlw_front
// Accept pixels, track column and row, fetch the up and up-right colors
// from the line store and queue a request with all neighbour colors.
// ----------------------------------------------------------------------------
module nlw_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [10:0]    image_width,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           start_of_frame,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic           q_full,
  output logic           q_push,
  output nlw_pkg::item_t q_data
);

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW1 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (CW1 > 11) ? CW1 : 11;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_UP   = 3'b010,
    F_UR   = 3'b100
  } front_state_t;

  front_state_t   state;
  front_state_t   state_next;
  logic [AW-1:0]  column_count;
  logic           past_first_row;
  logic [AW-1:0]  col_q;
  logic [23:0]    pix_q;
  logic [23:0]    up_q;
  logic [3:0]     ok_q;
  logic [23:0]    left_color;
  logic [23:0]    upleft_color;

  logic [WW-1:0]  raw_w;
  logic [WW-1:0]  eff_w;
  logic [AW-1:0]  c_start;
  logic           past_start;
  logic [WW-1:0]  c_plus1;
  logic           accept;
  logic [AW-1:0]  raddr;
  logic [23:0]    rdata;
  logic           we;

  // effective row width: zero counts as one, clip at the store depth
  always_comb begin
    raw_w = WW'(image_width);
    if (raw_w == '0) begin
      eff_w = WW'(1);
    end else if (raw_w > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = raw_w;
    end
  end

  // classify the incoming pixel: frame start, row wrap
  always_comb begin
    c_start    = start_of_frame ? '0 : column_count;
    past_start = start_of_frame ? 1'b0 : past_first_row;
    if (WW'(c_start) >= eff_w) begin
      c_start    = '0;
      past_start = 1'b1;
    end
    c_plus1 = WW'(c_start) + WW'(1);
  end

  assign in_ready = (state == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // line store read address: up at accept, up-right in the cycle after
  always_comb begin
    if (state == F_IDLE) begin
      raddr = c_start;
    end else if (ok_q[nlw_pkg::NB_UPRIGHT]) begin
      raddr = col_q + AW'(1);
    end else begin
      raddr = col_q;
    end
  end

  assign we = (state == F_UR);

  nlw_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (we),
    .waddr(col_q),
    .wdata(pix_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = F_UP;
        end
      end
      F_UP:    state_next = F_UR;
      F_UR:    state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      column_count   <= '0;
      past_first_row <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (c_plus1 >= eff_w) begin
          column_count   <= '0;
          past_first_row <= 1'b1;
        end else begin
          column_count   <= AW'(c_plus1);
          past_first_row <= past_start;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= c_start;
      pix_q <= {blue, green, red};
      ok_q  <= {past_start && (c_plus1 < eff_w),
                past_start,
                past_start && (c_start != '0),
                c_start != '0};
    end
    if (state == F_UP) begin
      up_q <= rdata;
    end
    if (state == F_UR) begin
      left_color   <= pix_q;
      upleft_color <= up_q;
    end
  end

  // hand the request to the queue
  always_comb begin
    q_push          = (state == F_UR);
    q_data.pix      = pix_q;
    q_data.left     = left_color;
    q_data.upleft   = upleft_color;
    q_data.up       = up_q;
    q_data.upright  = rdata;
    q_data.ok       = ok_q;
  end

endmodule

### src/nlw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlw_back
// Weight engine: for each of the four neighbours compute the squared color
// distance, scale by beta, evaluate exp(-x) bit by bit and scale by gamma.
// ----------------------------------------------------------------------------
`include "neighbour_edge_weights_assert.svh"

module nlw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    beta_scale,
  input  logic [21:0]    gamma_scale,
  input  logic [21:0]    gamma_diag,
  input  logic           q_empty,
  output logic           q_pop,
  input  nlw_pkg::item_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [21:0]    left_weight,
  output logic [21:0]    upleft_weight,
  output logic [21:0]    up_weight,
  output logic [21:0]    upright_weight
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_DIST  = 6'b000010,
    B_MULT  = 6'b000100,
    B_EXP   = 6'b001000,
    B_SCALE = 6'b010000,
    B_DONE  = 6'b100000
  } back_state_t;

  back_state_t    state;
  nlw_pkg::item_t item;
  logic [1:0]     k;
  logic [17:0]    d;
  logic [49:0]    x;
  logic [4:0]     step;
  logic [16:0]    e;
  logic [21:0]    res [4];

  logic [23:0]    nb;
  logic [21:0]    gain;
  logic           sat;
  logic [19:0]    xs;
  logic [33:0]    e_prod;
  logic [39:0]    w_prod;

  function automatic logic [17:0] sq_dist(input logic [23:0] a, input logic [23:0] b);
    logic [7:0]  df0;
    logic [7:0]  df1;
    logic [7:0]  df2;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    df0 = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
    df1 = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    df2 = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    s0  = 16'(df0) * 16'(df0);
    s1  = 16'(df1) * 16'(df1);
    s2  = 16'(df2) * 16'(df2);
    return 18'(s0) + 18'(s1) + 18'(s2);
  endfunction

  // pick the neighbour color and gain for the current slot
  always_comb begin
    case (k)
      nlw_pkg::NB_LEFT:   nb = item.left;
      nlw_pkg::NB_UPLEFT: nb = item.upleft;
      nlw_pkg::NB_UP:     nb = item.up;
      default:            nb = item.upright;
    endcase
    gain   = k[0] ? gamma_diag : gamma_scale;
    sat    = |x[49:28];
    xs     = x[27:8];
    e_prod = 34'(e) * 34'(nlw_pkg::exp_step(step)) + 34'd32768;
    w_prod = 40'(gain) * 40'(e) + 40'd32768;
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  // sequencer over the four neighbours
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      k         <= 2'd0;
      step      <= 5'd0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            k     <= 2'd0;
            state <= B_DIST;
          end
        end
        B_DIST: state <= B_MULT;
        B_MULT: begin
          step  <= 5'd0;
          state <= B_EXP;
        end
        B_EXP: begin
          if (sat || step == 5'(nlw_pkg::EXP_STEPS - 1)) begin
            state <= B_SCALE;
          end else begin
            step <= step + 5'd1;
          end
        end
        B_SCALE: begin
          k <= k + 2'd1;
          if (k == nlw_pkg::NB_UPRIGHT) begin
            state <= B_DONE;
          end else begin
            state <= B_DIST;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // raise the result valid when loaded, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_data;
    end
    if (state == B_DIST) begin
      d <= sq_dist(item.pix, nb);
    end
    if (state == B_MULT) begin
      x <= 50'(beta_scale) * 50'(d);
      e <= 17'd65536;
    end
    if (state == B_EXP) begin
      if (sat) begin
        e <= 17'd0;
      end else if (xs[5'd19 - step]) begin
        e <= e_prod[32:16];
      end
    end
    if (state == B_SCALE) begin
      res[k] <= item.ok[k] ? w_prod[37:16] : 22'd0;
    end
    if (state == B_DONE && (!out_valid || out_ready)) begin
      left_weight    <= res[nlw_pkg::NB_LEFT];
      upleft_weight  <= res[nlw_pkg::NB_UPLEFT];
      up_weight      <= res[nlw_pkg::NB_UP];
      upright_weight <= res[nlw_pkg::NB_UPRIGHT];
    end
  end

  `NLW_ASSERT_IMPLY(a_step_range, state == B_EXP, step < 5'd20)
  `NLW_ASSERT_IMPLY(a_pop_when_idle, q_pop, state == B_IDLE)
  `NLW_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid)

endmodule

### src/neighbour_edge_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_edge_weights
// Contrast-sensitive neighbour edge weights for a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_valid / in_ready channel in raster order, with
//   start_of_frame marking the first pixel of an image. For every pixel one
//   result leaves on out_valid / out_ready: the left, up-left, up and
//   up-right weights, each gamma * exp(-beta * d) in Q6.16 (gamma / sqrt2 on
//   the diagonals), zero where the neighbour lies outside the image.
//   Configuration (row width, beta, gamma) is written through cfg_write,
//   cfg_index and cfg_data while the block is idle.
//   Flow: the front end walks its idle, up and up-right states for each
//   pixel, taking no new pixel until it is back in idle, and queues up to
//   two requests. The weight engine runs its distance, multiply, exponent
//   and scale states for each of the four neighbours, the exponent state
//   ending early when it saturates, and pops a request only after the last
//   result is loaded; that engine, with its single shared exponent multiplier
//   walking 20 bits of the scaled distance, sets the rate.
//   Reset clears the row position and all handshake state; the line store
//   needs no clearing pass. A stalled receiver holds the result register;
//   the queue absorbs two more pixels before in_ready drops.
// ----------------------------------------------------------------------------
module neighbour_edge_weights #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_of_frame,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] left_weight,
  output logic [21:0] upleft_weight,
  output logic [21:0] up_weight,
  output logic [21:0] upright_weight
);

  logic [10:0]    image_width;
  logic [31:0]    beta_scale;
  logic [21:0]    gamma_scale;
  logic [21:0]    gamma_diag;
  logic [38:0]    diag_prod;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  nlw_pkg::item_t q_in;
  nlw_pkg::item_t q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      beta_scale  <= 32'd0;
      gamma_scale <= 22'd3276800;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nlw_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data[10:0];
        nlw_pkg::REG_BETA_SCALE:  beta_scale  <= cfg_data;
        nlw_pkg::REG_GAMMA_SCALE: gamma_scale <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  // diagonal gamma: gamma / sqrt2, rounded
  assign diag_prod = 39'(gamma_scale) * 39'(nlw_pkg::INV_SQRT2) + 39'd32768;

  always_ff @(posedge clk) begin
    gamma_diag <= diag_prod[37:16];
  end

  nlw_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .image_width   (image_width),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_of_frame(start_of_frame),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  nlw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  nlw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .beta_scale    (beta_scale),
    .gamma_scale   (gamma_scale),
    .gamma_diag    (gamma_diag),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_weight   (left_weight),
    .upleft_weight (upleft_weight),
    .up_weight     (up_weight),
    .upright_weight(upright_weight)
  );

endmodule

### test/neighbour_edge_weights_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_edge_weights_checker
// Watches the configuration port and both pixel channels of the neighbour
// edge weight block. It keeps its own line store and row position, works
// out the four weights of every accepted pixel request, and compares each
// accepted result against the oldest pending one.
// ----------------------------------------------------------------------------
module neighbour_edge_weights_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        start_of_frame,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [21:0] left_weight,
  input  logic [21:0] upleft_weight,
  input  logic [21:0] up_weight,
  input  logic [21:0] upright_weight,
  output int          pending,
  output int          failures
);

  typedef struct packed {
    logic [21:0] left;
    logic [21:0] upleft;
    logic [21:0] up;
    logic [21:0] upright;
  } weights_t;

  // round(65536 * exp(-2^k)) for k = 3 down to -16
  localparam logic [15:0] EXP_STEP_TAB [20] = '{
    16'd22, 16'd1200, 16'd8869, 16'd24109, 16'd39750, 16'd51039, 16'd57835,
    16'd61565, 16'd63520, 16'd64520, 16'd65026, 16'd65280, 16'd65408,
    16'd65472, 16'd65504, 16'd65520, 16'd65528, 16'd65532, 16'd65534,
    16'd65535};

  logic [10:0] width_reg;
  logic [31:0] beta_reg;
  logic [21:0] gamma_reg;
  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] left_pix;
  logic [23:0] upleft_pix;
  int unsigned col_pos;
  bit          below_first_row;
  weights_t    expected_weights [$];

  // squared RGB distance, then exp(-beta * d) in Q1.16
  function automatic logic [63:0] contrast_exp(logic [23:0] a, logic [23:0] b);
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] e;
    int          diff;
    d = 0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = int'(a[8*ch +: 8]) - int'(b[8*ch +: 8]);
      d += 64'(diff * diff);
    end
    x = 64'(beta_reg) * d;
    if (x >= (64'd16 << 24)) return 64'd0;
    e = 64'd65536;
    for (int i = 0; i < 20; i++) begin
      if (x[27 - i]) e = (e * 64'(EXP_STEP_TAB[i]) + 64'd32768) >> 16;
    end
    return e;
  endfunction

  function automatic logic [21:0] edge_weight(logic [63:0] g, logic [23:0] a,
                                              logic [23:0] b);
    logic [63:0] w;
    w = (g * contrast_exp(a, b) + 64'd32768) >> 16;
    return w[21:0];
  endfunction

  // advance the row position and return the weights of one pixel
  function automatic weights_t next_weights(logic sof, logic [23:0] pix);
    weights_t    res;
    int unsigned w;
    int unsigned c;
    logic [63:0] g;
    logic [63:0] g2;
    logic [23:0] up_pix;
    w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    g  = 64'(gamma_reg);
    g2 = (g * 64'(nlw_pkg::INV_SQRT2) + 64'd32768) >> 16;
    if (sof) begin
      col_pos = 0;
      below_first_row = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      below_first_row = 1;
    end
    c = col_pos;
    up_pix = line_mem[c];
    res.left    = (c > 0) ? edge_weight(g, pix, left_pix) : '0;
    res.upleft  = (c > 0 && below_first_row) ? edge_weight(g2, pix, upleft_pix) : '0;
    res.up      = below_first_row ? edge_weight(g, pix, up_pix) : '0;
    res.upright = (below_first_row && c + 1 < w) ?
                  edge_weight(g2, pix, line_mem[c + 1]) : '0;
    upleft_pix  = up_pix;
    line_mem[c] = pix;
    left_pix    = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      below_first_row = 1;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  assign pending = expected_weights.size();

  always @(posedge clk) begin
    weights_t exp_w;
    weights_t got_w;
    if (rst) begin
      width_reg       = 11'd1024;
      beta_reg        = 32'd0;
      gamma_reg       = 22'd3276800;
      col_pos         = 0;
      below_first_row = 0;
      expected_weights.delete();
    end else begin
      // track register writes
      if (cfg_write) begin
        case (cfg_index)
          nlw_pkg::REG_IMAGE_WIDTH: width_reg = cfg_data[10:0];
          nlw_pkg::REG_BETA_SCALE:  beta_reg  = cfg_data;
          nlw_pkg::REG_GAMMA_SCALE: gamma_reg = cfg_data[21:0];
          default: ;
        endcase
      end
      // predict each accepted pixel request
      if (in_valid && in_ready)
        expected_weights.insert(expected_weights.size(),
                                next_weights(start_of_frame, {blue, green, red}));
      // compare each accepted result
      if (out_valid && out_ready) begin
        got_w = '{left_weight, upleft_weight, up_weight, upright_weight};
        if (expected_weights.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result %h", got_w);
        end else begin
          exp_w = expected_weights.pop_front();
          if (exp_w != got_w) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: exp L=%0d UL=%0d U=%0d UR=%0d got L=%0d UL=%0d U=%0d UR=%0d",
                       exp_w.left, exp_w.upleft, exp_w.up, exp_w.upright,
                       got_w.left, got_w.upleft, got_w.up, got_w.upright);
          end
        end
      end
    end
  end

  initial failures = 0;

endmodule

### test/neighbour_edge_weights_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_edge_weights_test
// Drives pixel streams and register settings into the neighbour edge weight
// block: a directed part for borders, extremes and width changes, then
// random frames under several idle and stall patterns with one long receiver
// hold-off. The checker beside the block does all prediction and comparing.
// ----------------------------------------------------------------------------
module neighbour_edge_weights_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        start_of_frame;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        out_valid;
  logic        out_ready;
  logic [21:0] left_weight;
  logic [21:0] upleft_weight;
  logic [21:0] up_weight;
  logic [21:0] upright_weight;
  int          pending;
  int          failures;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_request;
  int          hold_left;
  int          quiet_cycles;
  logic [23:0] last_pix;

  neighbour_edge_weights u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .start_of_frame(start_of_frame),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_weight(left_weight), .upleft_weight(upleft_weight),
    .up_weight(up_weight), .upright_weight(upright_weight)
  );

  neighbour_edge_weights_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .start_of_frame(start_of_frame),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_weight(left_weight), .upleft_weight(upleft_weight),
    .up_weight(up_weight), .upright_weight(upright_weight),
    .pending(pending), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[neighbour_edge_weights] ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_pixel(logic sof, logic [23:0] rgb);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    start_of_frame = sof;
    {blue, green, red} = rgb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    last_pix = rgb;
  endtask

  // wait for every pending result, then let the engine go quiet
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random frames: mostly colors close to the previous pixel
  task automatic random_frames(int n);
    logic [23:0] pix;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) pix = $urandom;
      else pix = last_pix ^ 24'($urandom_range(7)) ^ (24'($urandom_range(7)) << 8)
                 ^ (24'($urandom_range(7)) << 16);
      send_pixel(i == 0 || $urandom_range(99) == 0, pix);
    end
  endtask

  initial begin
    int w;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; start_of_frame = 1'b0; red = '0; green = '0; blue = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_request = 0; hold_left = 0;
    quiet_cycles = 0; last_pix = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // corners of the color cube on a small image, gamma at its top
    write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'd4);
    write_reg(nlw_pkg::REG_BETA_SCALE, 32'h0000_1000);
    write_reg(nlw_pkg::REG_GAMMA_SCALE, 32'h003F_FFFF);
    send_pixel(1'b1, 24'h000000); send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'h0000FF); send_pixel(1'b0, 24'h00FF00);
    send_pixel(1'b0, 24'hFF0000); send_pixel(1'b0, 24'h000001);
    send_pixel(1'b0, 24'hFFFFFF); send_pixel(1'b0, 24'hFFFFFE);
    send_pixel(1'b0, 24'h808080); send_pixel(1'b0, 24'h7F7F7F);
    // new frame in the middle of a row
    send_pixel(1'b1, 24'h123456); send_pixel(1'b0, 24'h123457);
    drain();

    // lower the width in the middle of a row
    write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'd8);
    write_reg(nlw_pkg::REG_BETA_SCALE, 32'h0000_0000);
    write_reg(nlw_pkg::REG_GAMMA_SCALE, 32'd0);
    for (int i = 0; i < 13; i++) send_pixel(i == 0, $urandom);
    drain();
    write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'd3);
    write_reg(nlw_pkg::REG_GAMMA_SCALE, 32'd3276800);
    for (int i = 0; i < 4; i++) send_pixel(1'b0, $urandom);
    drain();

    // width zero acts as one column
    write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'd0);
    write_reg(nlw_pkg::REG_BETA_SCALE, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) send_pixel(1'b0, 24'h00000F << i);
    drain();

    // oversized width clamps to the line store; beta saturates most weights
    write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'h7FF);
    send_pixel(1'b1, 24'h000000);
    for (int i = 1; i < 1040; i++)
      send_pixel(1'b0, ($urandom_range(3) == 0) ? last_pix : 24'($urandom));
    drain();

    // random settings under each idle pattern
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      case ($urandom_range(9))
        0: w = $urandom_range(1);
        1: w = $urandom_range(2047);
        default: w = $urandom_range(2, 12);
      endcase
      write_reg(nlw_pkg::REG_IMAGE_WIDTH, 32'(w));
      write_reg(nlw_pkg::REG_BETA_SCALE, ($urandom_range(1) != 0) ?
                32'($urandom_range(0, 32'h0100_0000)) : 32'($urandom));
      write_reg(nlw_pkg::REG_GAMMA_SCALE, 32'($urandom_range(0, 22'h3FFFFF)));
      if (phase == 0) hold_request = 600;
      random_frames(45);
      drain();
    end

    if (failures == 0) begin
      $display("[neighbour_edge_weights] OK");
    end else begin
      $display("[neighbour_edge_weights] ERROR");
    end
    $finish;
  end

endmodule
